// ----- rtl/rotozoom_texture_fetch_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ROTOZOOM_TEXTURE_FETCH_MACROS_SVH
`define ROTOZOOM_TEXTURE_FETCH_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define RTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/rtf_pkg.sv -----
// Package: constants, types and helper functions for the rotozoom texture fetch.
package rtf_pkg;

    localparam int TexWidth     = 256;
    localparam int TexHeightMax = 256;
    localparam int AddrW        = 16;
    localparam int CoefW        = 20;
    localparam int CoordW       = 10;
    localparam int TexelW       = 32;
    localparam int RemW         = 9;
    localparam int MagW         = 16;
    localparam int DivBits      = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_COS    = 2'd0;
    localparam logic [1:0] CFG_SIN    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef logic signed [30:0] prod_t;
    typedef logic [RemW-1:0]    rem_t;
    typedef logic [MagW-1:0]    mag_t;

    // Unsigned coordinate times signed coefficient
    function automatic prod_t coef_mul(input logic [CoordW-1:0] c,
                                       input logic signed [CoefW-1:0] k);
        logic signed [30:0] cs;
        logic signed [30:0] ks;
        begin
            cs = $signed({21'd0, c});
            ks = 31'(k);
            coef_mul = cs * ks;
        end
    endfunction

    // Four restoring remainder steps; bits consumed MSB first
    function automatic rem_t rem_steps(input rem_t r_in,
                                       input logic [DivBits-1:0] bits,
                                       input rem_t h);
        logic [RemW:0] t;
        rem_t r;
        begin
            r = r_in;
            for (int i = DivBits - 1; i >= 0; i--) begin
                t = {r, bits[i]};
                if (t >= {1'b0, h}) begin
                    t = t - {1'b0, h};
                end
                r = t[RemW-1:0];
            end
            rem_steps = r;
        end
    endfunction

endpackage

// ----- rtl/rotozoom_texture_fetch.sv -----
// Rotozoom texture fetch: rotate/scale a pixel and read the texel at the source.
// The pipeline stages are products, sums, four remainder stages, address and
// texture read. Throughput: one request per cycle while out_ready does not stall it;
// the height modulo is spread over four pipeline stages of four steps each.
// Loads write the texture at the read stage and give no result. Reset clears
// the valid bits and sets cos 1.0, sin 0, height 256; texture content is not cleared.
module rotozoom_texture_fetch
    import rtf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [CoefW-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic [CoordW-1:0]        coord_x,
    input  logic [CoordW-1:0]        coord_y,
    input  logic [TexelW-1:0]        texel_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CoordW-1:0]        dest_x,
    output logic [CoordW-1:0]        dest_y,
    output logic [TexelW-1:0]        color
);

    localparam int NStg = 8;

    // Configuration registers
    logic signed [CoefW-1:0] cos_reg;
    logic signed [CoefW-1:0] sin_reg;
    logic [RemW-1:0]         height_reg;
    rem_t                    h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= 20'sd65536;
            sin_reg    <= '0;
            height_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COS:    cos_reg    <= cfg_data;
                CFG_SIN:    sin_reg    <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data[RemW-1:0];
                default:    ;
            endcase
        end
    end

    // Height clamped to 1..256
    always_comb
    begin
        if (height_reg == '0)
            h_eff = 9'd1;
        else if (height_reg > 9'(TexHeightMax))
            h_eff = 9'(TexHeightMax);
        else
            h_eff = height_reg;
    end

    // Stage handshake: a stage loads when empty or when it drains
    logic [NStg-1:0] v_reg;
    logic [NStg:0]   adv;

    always_comb
    begin
        adv[NStg] = out_ready;
        for (int k = NStg - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NStg-1];

    // Fields carried alongside the work
    logic [CoordW-1:0] x_reg     [0:NStg-1];
    logic [CoordW-1:0] y_reg     [0:NStg-1];
    logic              mode_reg  [0:NStg-2];
    logic [TexelW-1:0] texel_reg [0:NStg-2];
    logic [AddrW-1:0]  waddr_reg [0:NStg-2];

    // Stage specific payload
    prod_t pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic [7:0]       col_reg [1:6];
    logic             neg_reg [1:5];
    mag_t             mag_reg [1:5];
    rem_t             rem_reg [2:5];
    logic [AddrW-1:0] raddr_reg;
    logic [TexelW-1:0] color_reg;

    // Sum and truncate toward zero
    logic signed [31:0] u_sum, v_sum, u_trunc, v_trunc;
    logic signed [15:0] vi;
    always_comb
    begin
        u_sum   = 32'(pxc_reg) - 32'(pys_reg);
        v_sum   = 32'(pxs_reg) + 32'(pyc_reg);
        u_trunc = u_sum + (u_sum[31] ? 32'sd65535 : 32'sd0);
        v_trunc = v_sum + (v_sum[31] ? 32'sd65535 : 32'sd0);
        vi      = v_trunc[31:16];
    end

    // Final row correction for negative quotients
    logic [RemW-1:0] row_full;
    always_comb
    begin
        if (neg_reg[5] && rem_reg[5] != '0)
            row_full = h_eff - rem_reg[5];
        else
            row_full = rem_reg[5];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NStg - 1; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
            // loads end at the texture stage
            if (adv[NStg-1])
                v_reg[NStg-1] <= v_reg[NStg-2] && mode_reg[NStg-2];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x_reg[0]     <= coord_x;
            y_reg[0]     <= coord_y;
            mode_reg[0]  <= mode;
            texel_reg[0] <= texel_in;
            waddr_reg[0] <= {coord_y[7:0], coord_x[7:0]};
            pxc_reg      <= coef_mul(coord_x, cos_reg);
            pys_reg      <= coef_mul(coord_y, sin_reg);
            pxs_reg      <= coef_mul(coord_x, sin_reg);
            pyc_reg      <= coef_mul(coord_y, cos_reg);
        end
        for (int k = 1; k < NStg - 1; k++)
        begin
            if (adv[k])
            begin
                x_reg[k]     <= x_reg[k-1];
                y_reg[k]     <= y_reg[k-1];
                mode_reg[k]  <= mode_reg[k-1];
                texel_reg[k] <= texel_reg[k-1];
                waddr_reg[k] <= waddr_reg[k-1];
            end
        end
        if (adv[NStg-1])
        begin
            x_reg[NStg-1] <= x_reg[NStg-2];
            y_reg[NStg-1] <= y_reg[NStg-2];
        end
        // sums and sign split
        if (adv[1])
        begin
            col_reg[1] <= u_trunc[23:16];
            neg_reg[1] <= vi[15];
            mag_reg[1] <= vi[15] ? MagW'(-vi) : MagW'(vi);
        end
        // remainder stages
        if (adv[2])
        begin
            col_reg[2] <= col_reg[1];
            neg_reg[2] <= neg_reg[1];
            mag_reg[2] <= {mag_reg[1][MagW-DivBits-1:0], {DivBits{1'b0}}};
            rem_reg[2] <= rem_steps('0, mag_reg[1][MagW-1 -: DivBits], h_eff);
        end
        for (int k = 3; k <= 5; k++)
        begin
            if (adv[k])
            begin
                col_reg[k] <= col_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                mag_reg[k] <= {mag_reg[k-1][MagW-DivBits-1:0], {DivBits{1'b0}}};
                rem_reg[k] <= rem_steps(rem_reg[k-1], mag_reg[k-1][MagW-1 -: DivBits],
                                        h_eff);
            end
        end
        // texture address
        if (adv[6])
        begin
            col_reg[6] <= col_reg[5];
            raddr_reg  <= {row_full[7:0], col_reg[5]};
        end
    end

    // Texture store: one write or one read per cycle at the last stage, when that stage advances
    logic [TexelW-1:0] tex_mem [0:(1<<AddrW)-1];

    always_ff @(posedge clk)
    begin
        if (adv[NStg-1] && v_reg[NStg-2])
        begin
            if (!mode_reg[NStg-2])
                tex_mem[waddr_reg[NStg-2]] <= texel_reg[NStg-2];
            else
                color_reg <= tex_mem[raddr_reg];
        end
    end

    assign dest_x = x_reg[NStg-1];
    assign dest_y = y_reg[NStg-1];
    assign color  = color_reg;

endmodule

// ----- rtl/rtf_checker.sv -----
// Port-level checker for the rotozoom texture fetch, bound to the top level.
`include "rotozoom_texture_fetch_macros.svh"

module rtf_checker
    import rtf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_ready,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [TexelW-1:0] color
);

    // A taken output always frees the input side
    `RTF_ASSERT_NOW(a_ready_flow, clk, rst_n, out_ready, in_ready)
    // Input stalls only come from a blocked output
    `RTF_ASSERT_NOW(a_stall_src, clk, rst_n, !in_ready, out_valid && !out_ready)
    // Configuration is never refused
    `RTF_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
    // Stalled request holds its texel
    `RTF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(color))

endmodule

bind rotozoom_texture_fetch rtf_checker u_rtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .color     (color)
);

// ----- bench/tb_rotozoom_texture_fetch.sv -----
// Testbench for the rotozoom texture fetch: loads, rotated/scaled renders, register phases.
module tb_rotozoom_texture_fetch;
    import rtf_pkg::*;

    typedef struct packed {
        logic              mode;
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [TexelW-1:0] texel;
    } tex_req_t;

    typedef struct packed {
        logic [CoordW-1:0] dx;
        logic [CoordW-1:0] dy;
        logic [TexelW-1:0] color;
    } pixel_t;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_RENDER = 1'b1;
    localparam int   IDLE_LIMIT  = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_COS;
    logic [CoefW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = MODE_LOAD;
    logic [CoordW-1:0] coord_x = '0;
    logic [CoordW-1:0] coord_y = '0;
    logic [TexelW-1:0] texel_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
    logic [TexelW-1:0] color;

    rotozoom_texture_fetch dut (.*);

    // Predictor state, updated on accepted requests and register writes
    logic [TexelW-1:0] texels [0:65535];
    logic signed [CoefW-1:0] cur_cos = 20'sd65536;
    logic signed [CoefW-1:0] cur_sin = 20'sd0;
    logic [8:0] cur_height = 9'd256;

    // Stimulus-side view of which entries will have been loaded
    bit planned_written [0:65535];

    tex_req_t pending_reqs[$];
    pixel_t   expected_pixels[$];
    int mismatches = 0;
    int idle_cycles = 0;

    // Source texel address for a destination pixel
    function automatic logic [15:0] source_addr(input logic [CoordW-1:0] x,
                                                input logic [CoordW-1:0] y,
                                                input logic signed [CoefW-1:0] c,
                                                input logic signed [CoefW-1:0] s,
                                                input logic [8:0] h9);
        longint u, v, ui, vi, h, row;
        begin
            u = longint'(x) * longint'(c) - longint'(y) * longint'(s);
            v = longint'(x) * longint'(s) + longint'(y) * longint'(c);
            ui = u / 65536;
            vi = v / 65536;
            h = (h9 == 0) ? 1 : (h9 > TexHeightMax) ? TexHeightMax : h9;
            row = vi % h;
            if (row < 0)
            begin
                row = row + h;
            end
            source_addr = {row[7:0], ui[7:0]};
        end
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        begin
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            mismatches++;
        end
    endtask

    // Queue a render; load its source texel first if still unwritten
    task automatic add_render(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
        tex_req_t r;
        logic [15:0] a;
        begin
            a = source_addr(x, y, cur_cos, cur_sin, cur_height);
            if (!planned_written[a])
            begin
                r.mode = MODE_LOAD;
                r.cx = {2'($urandom), a[7:0]};
                r.cy = {2'($urandom), a[15:8]};
                r.texel = $urandom;
                pending_reqs.push_back(r);
                planned_written[a] = 1'b1;
            end
            r.mode = MODE_RENDER;
            r.cx = x;
            r.cy = y;
            r.texel = $urandom;
            pending_reqs.push_back(r);
        end
    endtask

    task automatic add_load(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                            input logic [TexelW-1:0] t);
        tex_req_t r;
        begin
            r.mode = MODE_LOAD;
            r.cx = x;
            r.cy = y;
            r.texel = t;
            pending_reqs.push_back(r);
            planned_written[{y[7:0], x[7:0]}] = 1'b1;
        end
    endtask

    function automatic logic [CoordW-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: pick_coord = '0;
            1: pick_coord = '1;
            2: pick_coord = CoordW'($urandom_range(0, 15));
            default: pick_coord = CoordW'($urandom);
        endcase
    endfunction

    // Wait for the pipeline to drain, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [CoefW-1:0] val);
        begin
            wait (pending_reqs.size() == 0 && !in_valid && expected_pixels.size() == 0);
            repeat (12) @(posedge clk);
            cfg_index <= idx;
            cfg_data <= val;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            cfg_valid <= 1'b0;
            case (idx)
                CFG_COS: cur_cos = val;
                CFG_SIN: cur_sin = val;
                default: cur_height = val[8:0];
            endcase
        end
    endtask

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stimulus: directed requests, then random phases over register settings
    initial
    begin
        logic signed [CoefW-1:0] cos_set [0:9];
        logic signed [CoefW-1:0] sin_set [0:9];
        logic [CoefW-1:0] height_set [0:9];
        cos_set    = '{20'sd65536, 20'sd262144, -20'sd262144, 20'sd0, 20'sd46341,
                       -20'sd524288, 20'sd524287, 20'sd3000, -20'sd60000, 20'sd16384};
        sin_set    = '{20'sd0, 20'sd262144, -20'sd262144, 20'sd65536, 20'sd46341,
                       20'sd524287, -20'sd524288, -20'sd70000, 20'sd1, -20'sd16384};
        height_set = '{20'd256, 20'd1, 20'd256, 20'd0, 20'd100,
                       20'd511, 20'd7, 20'd255, 20'd300, 20'd3};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corner loads (upper bits wrap) and renders at default settings
        add_load(10'd0, 10'd0, 32'h0000_0000);
        add_load(10'd1023, 10'd1023, 32'hFFFF_FFFF);
        add_load(10'd256, 10'd512, 32'hA5A5_5A5A);
        add_load(10'd255, 10'd0, 32'h5A5A_A5A5);
        add_render(10'd0, 10'd0);
        add_render(10'd1023, 10'd1023);
        add_render(10'd255, 10'd0);
        add_render(10'd0, 10'd1023);
        add_render(10'd1023, 10'd0);
        add_render(10'd256, 10'd512);

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(CFG_COS, cos_set[ph]);
                write_reg(CFG_SIN, sin_set[ph]);
                write_reg(CFG_HEIGHT, height_set[ph]);
            end
            for (int i = 0; i < 55; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    add_render(pick_coord(), pick_coord());
                end
                else
                begin
                    add_load(CoordW'($urandom), CoordW'($urandom), $urandom);
                end
            end
        end

        wait (pending_reqs.size() == 0 && !in_valid && expected_pixels.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Request driver: bursts and gaps, predicting on acceptance
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge clk)
    begin
        tex_req_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                if (mode == MODE_LOAD)
                begin
                    texels[{coord_y[7:0], coord_x[7:0]}] = texel_in;
                end
                else
                begin
                    expected_pixels.push_back({coord_x, coord_y,
                        texels[source_addr(coord_x, coord_y, cur_cos, cur_sin, cur_height)]});
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                mode <= r.mode;
                coord_x <= r.cx;
                coord_y <= r.cy;
                texel_in <= r.texel;
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall pattern: out_ready follows a style that is picked at random anew
    int stall_cnt = 0;
    int stall_style = 0;
    always @(posedge clk)
    begin
        stall_cnt++;
        if (stall_cnt % 64 == 0)
        begin
            stall_style = $urandom_range(0, 3);
        end
        case (stall_style)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 9) < 7);
            2: out_ready <= (stall_cnt % 5 != 0);
            default: out_ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // Result monitor
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report("unexpected pixel", {dest_x, dest_y, color}, 64'd0);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (dest_x !== want.dx) report("dest_x", dest_x, want.dx);
                if (dest_y !== want.dy) report("dest_y", dest_y, want.dy);
                if (color !== want.color) report("color", color, want.color);
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rtf_pkg.sv
rtl/rotozoom_texture_fetch.sv
rtl/rtf_checker.sv
bench/tb_rotozoom_texture_fetch.sv
